[design/sync_length_xor_frame_deframer_top_macros.svh]
`ifndef SYNC_LENGTH_XOR_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_DEFRAMER_TOP_MACROS_SVH

// implication check on the block clock, off during reset
`define SLDF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never hold
`define SLDF_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

[design/sldf_pkg.sv]
package sldf_pkg;

   localparam logic [7:0] SYNC_A            = 8'hAA;
   localparam logic [7:0] SYNC_B            = 8'h55;
   localparam int         LEN_MAX           = 60;
   localparam int         BUF_DEPTH_DEFAULT = 64;
   localparam int         IDX_W             = 6;
   localparam logic [5:0] MAX_PAYLOAD_RESET = 6'd60;

   typedef enum logic [2:0] {
      HUNT,
      SYNC2,
      CMD,
      LEN,
      PAYLOAD,
      CHK,
      REPLAY
   } phase_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } buf_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } buf_rd_type;

endpackage

[design/sldf_buf.sv]
module sldf_buf #(
   parameter int BUF_DEPTH = sldf_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  sldf_pkg::buf_wr_type wr,
   input  sldf_pkg::buf_rd_type rd,
   output logic [7:0]          rd_data
);

   localparam int AW = $clog2(BUF_DEPTH);

   logic [7:0] store_ff [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= store_ff[rd.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sync_length_xor_frame_deframer_top.sv]
// channel   | direction | handshake            | payload
// req       | in        | req_valid/req_ready  | req_rx_byte
// rsp       | out       | rsp_valid/rsp_ready  | rsp_command .. rsp_last
// csr       | in        | csr_valid/csr_ready  | csr_max_payload
//
// one received byte is taken per cycle while a frame is being collected, but the
// checksum byte waits while rsp is valid; a good checksum byte starts a replay of N
// payload results from the buffer read port, one per cycle unless rsp stalls; no byte is taken meanwhile
// an empty frame gives its one result straight from the checksum byte
// synchronous reset clears control state; the payload buffer is not cleared
// a stalled rsp holds the replay; csr writes are always taken
`include "sync_length_xor_frame_deframer_top_macros.svh"

module sync_length_xor_frame_deframer_top #(
   parameter int BUF_DEPTH = sldf_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_command,
   output logic [5:0] rsp_payload_len,
   output logic [5:0] rsp_byte_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_payload,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_max_payload
);

   localparam int LenCap = (BUF_DEPTH < sldf_pkg::LEN_MAX) ? BUF_DEPTH : sldf_pkg::LEN_MAX;

   sldf_pkg::phase_type state_ff, state_in;
   logic [5:0] max_ff;
   logic [7:0] cmd_ff, cmd_in;
   logic [5:0] len_ff, len_in;
   logic [5:0] fill_ff, fill_in;
   logic [7:0] xor_ff, xor_in;
   logic [5:0] rd_idx_ff, rd_idx_in;
   logic       pend_ff, pend_in;
   logic [5:0] pend_idx_ff, pend_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_cmd_ff, rsp_cmd_in;
   logic [5:0] rsp_len_ff, rsp_len_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_has_ff, rsp_has_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       acc;
   logic       load_pend;
   logic       load_empty;
   logic       issue;
   logic [6:0] lim;
   logic [5:0] fill_next;
   logic [7:0] rd_data;

   sldf_pkg::buf_wr_type wr;
   sldf_pkg::buf_rd_type rd;

   sldf_buf #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr     (wr),
      .rd     (rd),
      .rd_data(rd_data)
   );

   assign csr_ready = 1'b1;
   assign lim       = ({1'b0, max_ff} > 7'(LenCap)) ? 7'(LenCap) : {1'b0, max_ff};
   assign fill_next = fill_ff + 6'd1;

   assign req_ready = (state_ff != sldf_pkg::REPLAY) &&
                      !((state_ff == sldf_pkg::CHK) && rsp_valid_ff);
   assign acc       = req_valid && req_ready;
   assign load_pend = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue     = (state_ff == sldf_pkg::REPLAY) && (rd_idx_ff != len_ff) &&
                      (!pend_ff || load_pend);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      fill_in    = fill_ff;
      xor_in     = xor_ff;
      rd_idx_in  = rd_idx_ff;
      load_empty = 1'b0;
      wr.en      = 1'b0;
      wr.addr    = fill_ff;
      wr.data    = req_rx_byte;
      rd.en      = issue;
      rd.addr    = rd_idx_ff;
      case (state_ff)
         sldf_pkg::SYNC2: begin
            if (acc) begin
               state_in = (req_rx_byte == sldf_pkg::SYNC_B) ? sldf_pkg::CMD : sldf_pkg::HUNT;
            end
         end
         sldf_pkg::CMD: begin
            if (acc) begin
               cmd_in   = req_rx_byte;
               xor_in   = req_rx_byte;
               state_in = sldf_pkg::LEN;
            end
         end
         sldf_pkg::LEN: begin
            if (acc) begin
               xor_in  = xor_ff ^ req_rx_byte;
               fill_in = '0;
               if (req_rx_byte == 8'd0) begin
                  len_in   = '0;
                  state_in = sldf_pkg::CHK;
               end else if (req_rx_byte > {1'b0, lim}) begin
                  state_in = sldf_pkg::HUNT;
               end else begin
                  len_in   = req_rx_byte[5:0];
                  state_in = sldf_pkg::PAYLOAD;
               end
            end
         end
         sldf_pkg::PAYLOAD: begin
            if (acc) begin
               wr.en   = 1'b1;
               xor_in  = xor_ff ^ req_rx_byte;
               fill_in = fill_next;
               if (fill_next >= len_ff) begin
                  state_in = sldf_pkg::CHK;
               end
            end
         end
         sldf_pkg::CHK: begin
            if (acc) begin
               state_in = sldf_pkg::HUNT;
               if (req_rx_byte == xor_ff) begin
                  if (len_ff == 6'd0) begin
                     load_empty = 1'b1;
                  end else begin
                     rd_idx_in = '0;
                     state_in  = sldf_pkg::REPLAY;
                  end
               end
            end
         end
         sldf_pkg::REPLAY: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + 6'd1;
            end
            // leave only once the buffer read stage has drained
            if ((rd_idx_ff == len_ff) && (!pend_ff || load_pend)) begin
               state_in = sldf_pkg::HUNT;
            end
         end
         default: begin
            if (acc) begin
               state_in = (req_rx_byte == sldf_pkg::SYNC_A) ? sldf_pkg::SYNC2 : sldf_pkg::HUNT;
            end
         end
      endcase
   end

   always_comb begin
      pend_in      = issue ? 1'b1 : (load_pend ? 1'b0 : pend_ff);
      pend_idx_in  = issue ? rd_idx_ff : pend_idx_ff;
      rsp_valid_in = (load_pend || load_empty) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_pend) begin
         rsp_cmd_in  = cmd_ff;
         rsp_len_in  = len_ff;
         rsp_idx_in  = pend_idx_ff;
         rsp_byte_in = rd_data;
         rsp_has_in  = 1'b1;
         rsp_last_in = (pend_idx_ff + 6'd1) == len_ff;
      end else if (load_empty) begin
         rsp_cmd_in  = cmd_ff;
         rsp_len_in  = '0;
         rsp_idx_in  = '0;
         rsp_byte_in = '0;
         rsp_has_in  = 1'b0;
         rsp_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sldf_pkg::HUNT;
         max_ff       <= sldf_pkg::MAX_PAYLOAD_RESET;
         cmd_ff       <= '0;
         len_ff       <= '0;
         fill_ff      <= '0;
         xor_ff       <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         fill_ff      <= fill_in;
         xor_ff       <= xor_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = rsp_cmd_ff;
   assign rsp_payload_len  = rsp_len_ff;
   assign rsp_byte_index   = rsp_idx_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_has_payload  = rsp_has_ff;
   assign rsp_last         = rsp_last_ff;

   `SLDF_ASSERT(a_pend_in_replay, pend_ff |-> (state_ff == sldf_pkg::REPLAY), "read in flight outside replay")
   `SLDF_ASSERT(a_issue_pends, issue |=> pend_ff, "buffer read lost")
   `SLDF_ASSERT(a_idx_in_frame, (rsp_valid_ff && rsp_has_ff) |-> (rsp_idx_ff < rsp_len_ff), "item index beyond frame")
   `SLDF_ASSERT(a_empty_shape, (rsp_valid_ff && !rsp_has_ff) |-> (rsp_len_ff == 6'd0 && rsp_last_ff), "bad empty frame item")
   `SLDF_NEVER(a_no_wr_replay, wr.en && (state_ff == sldf_pkg::REPLAY), "buffer write during replay")

endmodule
